>>> rtl/core/jst_pkg.sv
// Package for the JSON subset tokenizer: capacity, widths, token and mode
// codes, character constants and shared helper functions. No dependencies.
package jst_pkg;

  // Capacity of one document in bytes
  localparam int MAX_INPUT = 65536;
  // Width that holds offsets and lengths up to and including MAX_INPUT
  localparam int POS_W     = $clog2(MAX_INPUT + 1);
  localparam int OUT_W     = 16;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef enum logic [2:0] {
    KIND_LBRACE = 3'd0,
    KIND_RBRACE = 3'd1,
    KIND_COMMA  = 3'd2,
    KIND_COLON  = 3'd3,
    KIND_STRING = 3'd4,
    KIND_NUMBER = 3'd5,
    KIND_ERROR  = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_STR  = 2'd1,
    MODE_NUM  = 2'd2,
    MODE_ERR  = 2'd3
  } mode_t;

  typedef struct packed {
    kind_t              kind;
    logic [OUT_W-1:0]   start_res;
    logic [OUT_W-1:0]   length;
    logic               last_of_run;
  } tok_t;

  // Tokens caused by one byte, packed from slot 0 upward
  typedef struct packed {
    logic [1:0] count;
    tok_t       tok0;
    tok_t       tok1;
  } tok_pair_t;

  // Saturate an offset or length to the 16-bit result field
  function automatic logic [OUT_W-1:0] sat16(input logic [POS_W-1:0] v);
    logic [POS_W+OUT_W-1:0] w;
    w = {{OUT_W{1'b0}}, v};
    if (w > (POS_W + OUT_W)'(17'h0FFFF)) begin
      return {OUT_W{1'b1}};
    end
    return w[OUT_W-1:0];
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

>>> rtl/core/jst_stream_if.sv
// Stream interfaces of the JSON subset tokenizer: one for text bytes and one
// for tokens, each with valid/ready. Depends on jst_pkg.
interface jst_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_input;

  modport source (output valid, output ch, output end_of_input, input ready);
  modport sink   (input valid, input ch, input end_of_input, output ready);
endinterface

interface jst_out_if
  import jst_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [2:0]       kind;
  logic [OUT_W-1:0] start_res;
  logic [OUT_W-1:0] length;
  logic             last_of_run;

  modport source (output valid, output kind, output start_res, output length,
                  output last_of_run, input ready);
  modport sink   (input valid, input kind, input start_res, input length,
                  input last_of_run, output ready);
endinterface

>>> rtl/core/json_subset_tokenizer_core.sv
// Top level of the JSON subset tokenizer: input register, lexer and token
// queue. Depends on jst_pkg, jst_stream_if, jst_lexer and jst_out_fifo.
//
//  channel   | dir | payload                                 | beat
//  ----------+-----+-----------------------------------------+------------------
//  in_bus    | in  | ch[7:0], end_of_input                   | one text byte
//  out_bus   | out | kind[2:0], start_res[15:0], length[15:0],| one token
//            |     | last_of_run                             |
//
// One byte per cycle is sustained while the queue has room; a byte is held in
// the input register, and its tokens enter the token queue when it is lexed.
// A byte yields zero, one or two tokens; the single-read token queue sets the
// rate at one token per cycle when out_bus is ready; two-token bytes outpace it.
// Reset (rst_n low, synchronous) empties both registers and clears the lexer
// to idle at offset zero. A stall on out_bus fills the queue; the lexer holds
// the registered byte, and stalls in_bus, until two queue slots are free.
module json_subset_tokenizer_core
  import jst_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  jst_in_if.sink      in_bus,
  jst_out_if.source   out_bus
);

  // Input register
  logic       in_valid_r;
  logic [7:0] ch_r;
  logic       eoi_r;
  logic       advance;
  logic       room2;
  tok_pair_t  toks;
  tok_t       out_tok;

  // Lex the held byte only when the queue can take both possible tokens
  assign advance      = in_valid_r && room2;
  assign in_bus.ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      in_valid_r <= in_bus.valid;
    end
  end

  // Payload needs no reset; load on each accepted beat
  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      ch_r  <= in_bus.ch;
      eoi_r <= in_bus.end_of_input;
    end
  end

  jst_lexer u_lexer (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (advance),
    .ch           (ch_r),
    .end_of_input (eoi_r),
    .toks         (toks)
  );

  jst_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (advance),
    .toks      (toks),
    .room2     (room2),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .out_tok   (out_tok)
  );

  assign out_bus.kind        = out_tok.kind;
  assign out_bus.start_res   = out_tok.start_res;
  assign out_bus.length      = out_tok.length;
  assign out_bus.last_of_run = out_tok.last_of_run;

endmodule

>>> rtl/core/jst_lexer.sv
// Lexer state machine: mode, position and pending token registers, and the
// per-byte token decode. Depends on jst_pkg.
module jst_lexer
  import jst_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       advance,
  input  logic [7:0] ch,
  input  logic       end_of_input,
  output tok_pair_t  toks
);

  mode_t            mode_r, mode_nxt, mode_mid;
  logic [POS_W-1:0] position_r, position_nxt;
  logic [POS_W-1:0] token_start_r, token_start_nxt, start_mid;
  logic [POS_W-1:0] token_length_r, token_length_nxt, len_mid;

  logic c_digit, c_ws, c_quote, c_punct, cap, idle_handle;
  kind_t punct_kind;
  logic [POS_W-1:0] len_bump;

  always_comb begin
    c_punct    = 1'b1;
    punct_kind = KIND_LBRACE;
    if (ch == CH_LBRACE) begin
      punct_kind = KIND_LBRACE;
    end else if (ch == CH_RBRACE) begin
      punct_kind = KIND_RBRACE;
    end else if (ch == CH_COMMA) begin
      punct_kind = KIND_COMMA;
    end else if (ch == CH_COLON) begin
      punct_kind = KIND_COLON;
    end else begin
      c_punct = 1'b0;
    end
  end

  assign c_digit  = is_digit(ch);
  assign c_ws     = is_ws(ch);
  assign c_quote  = (ch == CH_QUOTE);
  assign cap      = (position_r >= POS_W'(MAX_INPUT));
  assign len_bump = (token_length_r < POS_W'(MAX_INPUT)) ? token_length_r + 1'b1
                                                          : token_length_r;
  // Byte goes through idle handling: idle mode, or a digit run just ended
  assign idle_handle = (mode_r != MODE_ERR) && !cap &&
                       ((mode_r == MODE_IDLE) || ((mode_r == MODE_NUM) && !c_digit));

  // Next state
  always_comb begin
    mode_mid  = mode_r;
    start_mid = token_start_r;
    len_mid   = token_length_r;
    if (mode_r != MODE_ERR) begin
      if (cap) begin
        mode_mid = MODE_ERR;
      end else if (mode_r == MODE_STR) begin
        if (c_quote) begin
          mode_mid = MODE_IDLE;
        end else begin
          len_mid = len_bump;
        end
      end else if (mode_r == MODE_NUM) begin
        if (c_digit) begin
          len_mid = len_bump;
        end else begin
          mode_mid = MODE_IDLE;
        end
      end
    end
    if (idle_handle && !c_ws && !c_punct) begin
      if (c_quote) begin
        mode_mid  = MODE_STR;
        start_mid = position_r + 1'b1;
        len_mid   = '0;
      end else if (c_digit) begin
        mode_mid  = MODE_NUM;
        start_mid = position_r;
        len_mid   = POS_W'(1);
      end else begin
        mode_mid  = MODE_ERR;
      end
    end

    mode_nxt         = mode_r;
    position_nxt     = position_r;
    token_start_nxt  = token_start_r;
    token_length_nxt = token_length_r;
    if (advance) begin
      if (end_of_input) begin
        mode_nxt         = MODE_IDLE;
        position_nxt     = '0;
        token_start_nxt  = '0;
        token_length_nxt = '0;
      end else begin
        mode_nxt         = mode_mid;
        token_start_nxt  = start_mid;
        token_length_nxt = len_mid;
        if ((mode_r != MODE_ERR) && !cap) begin
          position_nxt = position_r + 1'b1;
        end
      end
    end
  end

  // Token outputs: stage token, idle-handling token, end-of-input flush
  always_comb begin
    tok_t c1, c2, c3;
    logic c1v, c2v, c3v;
    c1  = '{kind: KIND_ERROR, start_res: sat16(position_r), length: '0, last_of_run: 1'b0};
    c2  = '{kind: punct_kind, start_res: sat16(position_r), length: '0, last_of_run: 1'b0};
    c3  = '{kind: (mode_mid == MODE_STR) ? KIND_STRING : KIND_NUMBER,
            start_res: sat16(start_mid), length: sat16(len_mid), last_of_run: 1'b0};
    c1v = 1'b0;
    c2v = 1'b0;
    c3v = end_of_input && ((mode_mid == MODE_STR) || (mode_mid == MODE_NUM));
    if (mode_r != MODE_ERR) begin
      if (cap) begin
        c1v = 1'b1;
      end else if ((mode_r == MODE_STR) && c_quote) begin
        c1v = 1'b1;
        c1  = '{kind: KIND_STRING, start_res: sat16(token_start_r),
                length: sat16(token_length_r), last_of_run: 1'b0};
      end else if ((mode_r == MODE_NUM) && !c_digit) begin
        c1v = 1'b1;
        c1  = '{kind: KIND_NUMBER, start_res: sat16(token_start_r),
                length: sat16(token_length_r), last_of_run: 1'b0};
      end
    end
    if (idle_handle && !c_ws && !c_quote && !c_digit) begin
      c2v = 1'b1;
      if (!c_punct) begin
        c2.kind = KIND_ERROR;
      end
    end

    toks.count = 2'(c1v) + 2'(c2v) + 2'(c3v);
    if (c1v) begin
      toks.tok0 = c1;
      toks.tok1 = c2v ? c2 : c3;
    end else if (c2v) begin
      toks.tok0 = c2;
      toks.tok1 = c3;
    end else begin
      toks.tok0 = c3;
      toks.tok1 = c3;
    end
    toks.tok0.last_of_run = (toks.count == 2'd1);
    toks.tok1.last_of_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= MODE_IDLE;
      position_r     <= '0;
      token_start_r  <= '0;
      token_length_r <= '0;
    end else begin
      mode_r         <= mode_nxt;
      position_r     <= position_nxt;
      token_start_r  <= token_start_nxt;
      token_length_r <= token_length_nxt;
    end
  end

endmodule

>>> rtl/core/jst_out_fifo.sv
// Four-entry token queue: takes up to two tokens per cycle, hands out one.
// Depends on jst_pkg.
module jst_out_fifo
  import jst_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  tok_pair_t toks,
  output logic      room2,
  output logic      out_valid,
  input  logic      out_ready,
  output tok_t      out_tok
);

  tok_t       mem_r [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [2:0] count_r, count_nxt;
  logic       pop;
  logic [1:0] n_push;

  assign n_push    = push ? toks.count : 2'd0;
  assign pop       = out_valid && out_ready;
  assign out_valid = (count_r != 3'd0);
  assign out_tok   = mem_r[rd_ptr_r];
  assign room2     = (count_r <= 3'd2);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + n_push;
    rd_ptr_nxt = rd_ptr_r + 2'(pop);
    count_nxt  = count_r + 3'(n_push) - 3'(pop);
  end

  // Store payload
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem_r[wr_ptr_r] <= toks.tok0;
    end
    if (n_push == 2'd2) begin
      mem_r[wr_ptr_r + 2'd1] <= toks.tok1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
